// ===== src/jmr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmr_pkg
// Shared types and constants for the Jones matrix residual block.
// ----------------------------------------------------------------------------
package jmr_pkg;

    localparam int ANTENNAS_DEF = 64;
    localparam int CW = 16;
    localparam int FB = 12;
    localparam int ANT_BITS = 6;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [ANT_BITS-1:0] ant_i;
        logic [ANT_BITS-1:0] ant_j;
        logic [31:0]         model_00;
        logic [31:0]         model_01;
        logic [31:0]         model_10;
        logic [31:0]         model_11;
        logic [31:0]         obs_00;
        logic [31:0]         obs_01;
        logic [31:0]         obs_10;
        logic [31:0]         obs_11;
        logic                last_baseline;
    } in_word_t;

    typedef struct packed {
        logic [31:0] res_00;
        logic [31:0] res_01;
        logic [31:0] res_10;
        logic [31:0] res_11;
        logic        saturated;
        logic        batch_end;
    } out_word_t;

endpackage

// ===== src/jmr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/jmr_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmr_lane
// One output element: two-stage complex dot product, round, saturate, subtract.
// Stage one forms T row elements; stage two forms pred and residual.
// ----------------------------------------------------------------------------
module jmr_lane #(
    parameter int CWID = jmr_pkg::CW,
    parameter int FRAC = jmr_pkg::FB
) (
    input  logic                  clk,
    input  logic                  en1,
    input  logic                  en2,
    // stage one: T[r][0], T[r][1] = Ji[r][k] * Vm[k][c]
    input  logic [2*CWID-1:0]     ji0,
    input  logic [2*CWID-1:0]     ji1,
    input  logic [2*CWID-1:0]     vm0c0,
    input  logic [2*CWID-1:0]     vm1c0,
    input  logic [2*CWID-1:0]     vm0c1,
    input  logic [2*CWID-1:0]     vm1c1,
    // stage two: conj of Jj[c][k]
    input  logic [2*CWID-1:0]     jj0,
    input  logic [2*CWID-1:0]     jj1,
    input  logic [2*CWID-1:0]     obs,
    output logic [2*CWID-1:0]     res,
    output logic                  sat_flag
);

    localparam int IW = CWID + 4;
    localparam int PW = 2 * CWID + 8;
    localparam int QW = IW + CWID + 3;

    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] x;
        x = v + (PW'(1) <<< (FRAC - 1));
        return x >>> FRAC;
    endfunction

    function automatic logic signed [IW-1:0] satw(input logic signed [PW-1:0] v,
                                                  output logic f);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        hi = (PW'(1) <<< (IW - 1)) - PW'(1);
        lo = -hi - PW'(1);
        f = 1'b0;
        if (v > hi)
        begin
            f = 1'b1;
            return hi[IW-1:0];
        end
        if (v < lo)
        begin
            f = 1'b1;
            return lo[IW-1:0];
        end
        return v[IW-1:0];
    endfunction

    function automatic logic signed [CWID-1:0] satc(input logic signed [PW-1:0] v,
                                                    output logic f);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        hi = (PW'(1) <<< (CWID - 1)) - PW'(1);
        lo = -hi - PW'(1);
        f = 1'b0;
        if (v > hi)
        begin
            f = 1'b1;
            return hi[CWID-1:0];
        end
        if (v < lo)
        begin
            f = 1'b1;
            return lo[CWID-1:0];
        end
        return v[CWID-1:0];
    endfunction

    function automatic logic signed [CWID-1:0] re_of(input logic [2*CWID-1:0] p);
        return p[2*CWID-1:CWID];
    endfunction
    function automatic logic signed [CWID-1:0] im_of(input logic [2*CWID-1:0] p);
        return p[CWID-1:0];
    endfunction

    // stage one products
    logic signed [2*CWID-1:0] p1_reg [16];
    logic signed [2*CWID-1:0] p1_next [16];
    // stage one result
    logic signed [IW-1:0] t_reg [4];
    logic signed [IW-1:0] t_next [4];
    logic                 f1_reg, f1_next;
    logic [2*CWID-1:0]    jj0_reg, jj1_reg, obs_reg, obs2_reg;
    logic [2*CWID-1:0]    jjd0_reg, jjd1_reg, obs3_reg;
    logic [2*CWID-1:0]    jj0_next, jj1_next;
    logic signed [QW-1:0] p2_reg [8];
    logic signed [QW-1:0] p2_next [8];
    logic                 f2_reg;
    logic [2*CWID-1:0]    res_reg, res_next;
    logic                 f3_reg, f3_next;

    always_comb
    begin
        p1_next[0]  = re_of(ji0) * re_of(vm0c0);
        p1_next[1]  = im_of(ji0) * im_of(vm0c0);
        p1_next[2]  = re_of(ji0) * im_of(vm0c0);
        p1_next[3]  = im_of(ji0) * re_of(vm0c0);
        p1_next[4]  = re_of(ji1) * re_of(vm1c0);
        p1_next[5]  = im_of(ji1) * im_of(vm1c0);
        p1_next[6]  = re_of(ji1) * im_of(vm1c0);
        p1_next[7]  = im_of(ji1) * re_of(vm1c0);
        p1_next[8]  = re_of(ji0) * re_of(vm0c1);
        p1_next[9]  = im_of(ji0) * im_of(vm0c1);
        p1_next[10] = re_of(ji0) * im_of(vm0c1);
        p1_next[11] = im_of(ji0) * re_of(vm0c1);
        p1_next[12] = re_of(ji1) * re_of(vm1c1);
        p1_next[13] = im_of(ji1) * im_of(vm1c1);
        p1_next[14] = re_of(ji1) * im_of(vm1c1);
        p1_next[15] = im_of(ji1) * re_of(vm1c1);
    end

    always_comb
    begin
        logic signed [PW-1:0] s [4];
        logic                 f [4];
        for (int c = 0; c < 2; c++)
        begin
            s[2*c]   = PW'(p1_reg[8*c])   - PW'(p1_reg[8*c+1])
                     + PW'(p1_reg[8*c+4]) - PW'(p1_reg[8*c+5]);
            s[2*c+1] = PW'(p1_reg[8*c+2]) + PW'(p1_reg[8*c+3])
                     + PW'(p1_reg[8*c+6]) + PW'(p1_reg[8*c+7]);
        end
        for (int n = 0; n < 4; n++)
        begin
            t_next[n] = satw(rnd(s[n]), f[n]);
        end
        f1_next = f[0] | f[1] | f[2] | f[3];
    end

    assign jj0_next = jj0;
    assign jj1_next = jj1;

    // stage two products: T[r][k] * conj(Jj[c][k]); t index: 0 re0,1 im0,2 re1,3 im1
    always_comb
    begin
        p2_next[0] = QW'(t_reg[0] * re_of(jjd0_reg));
        p2_next[1] = QW'(t_reg[1] * im_of(jjd0_reg));
        p2_next[2] = QW'(t_reg[1] * re_of(jjd0_reg));
        p2_next[3] = QW'(t_reg[0] * im_of(jjd0_reg));
        p2_next[4] = QW'(t_reg[2] * re_of(jjd1_reg));
        p2_next[5] = QW'(t_reg[3] * im_of(jjd1_reg));
        p2_next[6] = QW'(t_reg[3] * re_of(jjd1_reg));
        p2_next[7] = QW'(t_reg[2] * im_of(jjd1_reg));
    end

    always_comb
    begin
        logic signed [PW-1:0] sr, si, dr, di;
        logic                 fr, fi;
        sr = PW'(p2_reg[0]) + PW'(p2_reg[1]) + PW'(p2_reg[4]) + PW'(p2_reg[5]);
        si = PW'(p2_reg[2]) - PW'(p2_reg[3]) + PW'(p2_reg[6]) - PW'(p2_reg[7]);
        dr = PW'(re_of(obs3_reg)) - rnd(sr);
        di = PW'(im_of(obs3_reg)) - rnd(si);
        res_next = {satc(dr, fr), satc(di, fi)};
        f3_next = f2_reg | fr | fi;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            p1_reg   <= p1_next;
            jj0_reg  <= jj0_next;
            jj1_reg  <= jj1_next;
            obs_reg  <= obs;
        end
        if (en2)
        begin
            t_reg    <= t_next;
            f1_reg   <= f1_next;
            jjd0_reg <= jj0_reg;
            jjd1_reg <= jj1_reg;
            obs2_reg <= obs_reg;
            obs3_reg <= obs2_reg;
            p2_reg   <= p2_next;
            f2_reg   <= f1_reg;
            res_reg  <= res_next;
            f3_reg   <= f3_next;
        end
    end

    assign res      = res_reg;
    assign sat_flag = f3_reg;

endmodule

// ===== src/jones_matrix_residual.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jones_matrix_residual
// Residual R = V_obs - J_i * V_model * J_j^H over a table of Jones matrices.
//
// Input channel (in_valid/in_stall/in_word): a load word (req_type 0) writes
// the four Jones elements of antenna ant_i into the table and gives no
// result. A compute word (req_type 1) reads antennas ant_i and ant_j and
// gives one result word on the output channel (out_valid/out_stall/out_word).
// The table sits in eight RAMs (a J_i copy and a J_j copy of each element),
// so both antennas read in one cycle; a load written in one cycle is
// seen by a compute word accepted the next cycle.
// One word per cycle is taken. A result word passes the RAM read at the
// accepting edge, then two multiply stages and two sum/round stages in turn,
// and then the output register. The whole
// pipeline advances only while the output register is free or being taken,
// so a stalled receiver holds every stage and raises in_stall.
// Reset clears the valid bits; table contents are undefined until loaded.
// Four lanes, one per residual element, run side by side; a merge stage ORs
// their saturation flags and packs the result word.
// ----------------------------------------------------------------------------
module jones_matrix_residual #(
    parameter int ANTENNAS = jmr_pkg::ANTENNAS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  jmr_pkg::in_word_t in_word,
    output logic              out_valid,
    input  logic              out_stall,
    output jmr_pkg::out_word_t out_word
);

    localparam int CW2 = 2 * jmr_pkg::CW;
    localparam int AW = (ANTENNAS > 1) ? $clog2(ANTENNAS) : 1;
    localparam int DEPTH = 1 << AW;
    localparam int STG = 5;

    logic adv;
    logic [STG-1:0] v_reg, v_next;
    logic [STG-2:0] last_reg;
    logic oor_i_reg, oor_j_reg;
    logic out_valid_reg;

    jmr_pkg::in_word_t w0_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    wire accept = in_valid && adv;
    wire is_load = in_word.req_type == jmr_pkg::REQ_LOAD;
    wire [jmr_pkg::ANT_BITS:0] ai_ext = {1'b0, in_word.ant_i};
    wire [jmr_pkg::ANT_BITS:0] aj_ext = {1'b0, in_word.ant_j};
    wire in_range_i = 32'(ai_ext) < ANTENNAS;
    wire in_range_j = 32'(aj_ext) < ANTENNAS;
    wire we = accept && is_load && in_range_i;
    wire [AW-1:0] wa = AW'(in_word.ant_i);
    wire [AW-1:0] ra_i = adv ? AW'(in_word.ant_i) : AW'(w0_reg.ant_i);
    wire [AW-1:0] ra_j = adv ? AW'(in_word.ant_j) : AW'(w0_reg.ant_j);

    logic [CW2-1:0] wd [4];
    assign wd[0] = in_word.model_00;
    assign wd[1] = in_word.model_01;
    assign wd[2] = in_word.model_10;
    assign wd[3] = in_word.model_11;

    logic [CW2-1:0] ji_raw [4];
    logic [CW2-1:0] jj_raw [4];
    logic [CW2-1:0] ji [4];
    logic [CW2-1:0] jj [4];

    for (genvar e = 0; e < 4; e++)
    begin : g_tab
        jmr_ram #(.WIDTH(CW2), .DEPTH(DEPTH)) u_ram_i (
            .clk(clk), .we(we), .waddr(wa), .wdata(wd[e]),
            .raddr(ra_i), .rdata(ji_raw[e])
        );
        jmr_ram #(.WIDTH(CW2), .DEPTH(DEPTH)) u_ram_j (
            .clk(clk), .we(we), .waddr(wa), .wdata(wd[e]),
            .raddr(ra_j), .rdata(jj_raw[e])
        );
        assign ji[e] = oor_i_reg ? '0 : ji_raw[e];
        assign jj[e] = oor_j_reg ? '0 : jj_raw[e];
    end

    // hold the RAM output while stalled: read address replays held word
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w0_reg    <= in_word;
            oor_i_reg <= !in_range_i;
            oor_j_reg <= !in_range_j;
        end
    end

    always_comb
    begin
        v_next    = {v_reg[STG-2:0], accept && !is_load};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= v_next;
            out_valid_reg <= v_reg[STG-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg <= {last_reg[STG-3:0], w0_reg.last_baseline};
        end
    end

    // lane inputs (stage 1 uses w0_reg and RAM data)
    logic [CW2-1:0] vm [4];
    logic [CW2-1:0] ob [4];
    assign vm[0] = w0_reg.model_00;
    assign vm[1] = w0_reg.model_01;
    assign vm[2] = w0_reg.model_10;
    assign vm[3] = w0_reg.model_11;
    assign ob[0] = w0_reg.obs_00;
    assign ob[1] = w0_reg.obs_01;
    assign ob[2] = w0_reg.obs_10;
    assign ob[3] = w0_reg.obs_11;

    logic [CW2-1:0] res [4];
    logic [3:0]     sf;

    // lane 2r+c: T row r (both columns), conj Jj row c
    for (genvar r = 0; r < 2; r++)
    begin : g_r
        for (genvar c = 0; c < 2; c++)
        begin : g_c
            jmr_lane u_lane (
                .clk(clk), .en1(adv), .en2(adv),
                .ji0(ji[2*r]), .ji1(ji[2*r+1]),
                .vm0c0(vm[0]), .vm1c0(vm[2]), .vm0c1(vm[1]), .vm1c1(vm[3]),
                .jj0(jj[2*c]), .jj1(jj[2*c+1]),
                .obs(ob[2*r+c]),
                .res(res[2*r+c]), .sat_flag(sf[2*r+c])
            );
        end
    end

    // merge: lanes finish at stage STG-1 alignment; output register
    jmr_pkg::out_word_t ow_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ow_reg.res_00    <= res[0];
            ow_reg.res_01    <= res[1];
            ow_reg.res_10    <= res[2];
            ow_reg.res_11    <= res[3];
            ow_reg.saturated <= |sf;
            ow_reg.batch_end <= last_reg[STG-2];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = ow_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output stall");
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_word.req_type == jmr_pkg::REQ_LOAD |=> !v_reg[0])
        else $error("load word entered compute pipeline");

endmodule

// ===== verif/jones_matrix_residual_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jones_matrix_residual_tb
// Loads Jones matrices and streams baselines through the residual block.
// Every result word is checked field by field against a fixed-point
// prediction, with random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module jones_matrix_residual_tb;

    localparam int WATCHDOG = 20000;
    localparam int NANT = jmr_pkg::ANTENNAS_DEF;
    localparam int ABITS = jmr_pkg::ANT_BITS;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    jmr_pkg::in_word_t  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    jmr_pkg::out_word_t out_word;

    jmr_pkg::in_word_t  pending_q[$];
    jmr_pkg::out_word_t residual_q[$];
    logic [31:0] jones_mem [0:NANT*4-1];
    bit        ant_loaded [0:NANT-1];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_cycles = 0;
    bit        stim_done = 1'b0;
    int        errors = 0;
    int        quiet = 0;

    jones_matrix_residual i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
    );

    always #1 clk = ~clk;

    function automatic longint round_q(longint v);
        return (v + (64'sd1 <<< (jmr_pkg::FB - 1))) >>> jmr_pkg::FB;
    endfunction

    function automatic longint clip(longint v, int w, ref bit flag);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin flag = 1'b1; return hi; end
        if (v < lo) begin flag = 1'b1; return lo; end
        return v;
    endfunction

    function automatic longint re_of(logic [31:0] p);
        return longint'(signed'(p[31:16]));
    endfunction

    function automatic longint im_of(logic [31:0] p);
        return longint'(signed'(p[15:0]));
    endfunction

    function automatic jmr_pkg::out_word_t residual(jmr_pkg::in_word_t w);
        logic [31:0] ji[4], jj[4], vm[4], vo[4];
        longint tr[4], ti[4];
        longint sr, si, rr, ri;
        bit flag;
        jmr_pkg::out_word_t o;
        flag = 1'b0;
        vm = '{w.model_00, w.model_01, w.model_10, w.model_11};
        vo = '{w.obs_00, w.obs_01, w.obs_10, w.obs_11};
        for (int e = 0; e < 4; e++) begin
            ji[e] = jones_mem[w.ant_i * 4 + e];
            jj[e] = jones_mem[w.ant_j * 4 + e];
        end
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < 2; c++)
            begin
                sr = 0; si = 0;
                for (int k = 0; k < 2; k++)
                begin
                    sr += re_of(ji[r*2+k]) * re_of(vm[k*2+c])
                        - im_of(ji[r*2+k]) * im_of(vm[k*2+c]);
                    si += re_of(ji[r*2+k]) * im_of(vm[k*2+c])
                        + im_of(ji[r*2+k]) * re_of(vm[k*2+c]);
                end
                tr[r*2+c] = clip(round_q(sr), jmr_pkg::CW + 4, flag);
                ti[r*2+c] = clip(round_q(si), jmr_pkg::CW + 4, flag);
            end
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < 2; c++)
            begin
                sr = 0; si = 0;
                for (int k = 0; k < 2; k++)
                begin
                    sr += tr[r*2+k] * re_of(jj[c*2+k]) + ti[r*2+k] * im_of(jj[c*2+k]);
                    si += ti[r*2+k] * re_of(jj[c*2+k]) - tr[r*2+k] * im_of(jj[c*2+k]);
                end
                rr = clip(re_of(vo[r*2+c]) - round_q(sr), jmr_pkg::CW, flag);
                ri = clip(im_of(vo[r*2+c]) - round_q(si), jmr_pkg::CW, flag);
                vo[r*2+c] = {rr[15:0], ri[15:0]};
            end
        o.res_00 = vo[0];
        o.res_01 = vo[1];
        o.res_10 = vo[2];
        o.res_11 = vo[3];
        o.saturated = flag;
        o.batch_end = w.last_baseline;
        return o;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            if (in_word.req_type == jmr_pkg::REQ_LOAD)
                for (int e = 0; e < 4; e++)
                    jones_mem[in_word.ant_i*4+e] <= in_word[256-32*e -: 32];
            else
                residual_q.push_back(residual(in_word));
        end
        if (!in_valid || !in_stall) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_word <= pending_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        jmr_pkg::out_word_t x;
        if (out_valid && !out_stall) begin
            if (residual_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                x = residual_q.pop_front();
                if (x.res_00 !== out_word.res_00) begin
                    $error("res_00 exp %h got %h", x.res_00, out_word.res_00); errors++; end
                if (x.res_01 !== out_word.res_01) begin
                    $error("res_01 exp %h got %h", x.res_01, out_word.res_01); errors++; end
                if (x.res_10 !== out_word.res_10) begin
                    $error("res_10 exp %h got %h", x.res_10, out_word.res_10); errors++; end
                if (x.res_11 !== out_word.res_11) begin
                    $error("res_11 exp %h got %h", x.res_11, out_word.res_11); errors++; end
                if (x.saturated !== out_word.saturated) begin
                    $error("saturated exp %b got %b", x.saturated, out_word.saturated);
                    errors++; end
                if (x.batch_end !== out_word.batch_end) begin
                    $error("batch_end exp %b got %b", x.batch_end, out_word.batch_end);
                    errors++; end
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] rnd_cplx();
        case ($urandom_range(5))
            0: return 32'h7FFF_7FFF;
            1: return 32'h8000_8000;
            2: return {$urandom_range(1) ? 16'h1000 : 16'hF000, 16'h0000};
            3: return {16'($urandom_range(8191)) - 16'd4096, 16'($urandom_range(8191)) - 16'd4096};
            default: return $urandom;
        endcase
    endfunction

    function automatic jmr_pkg::in_word_t load_word(int a, bit extreme);
        jmr_pkg::in_word_t w;
        w = '0;
        w.req_type = jmr_pkg::REQ_LOAD;
        w.ant_i = ABITS'(a);
        w.ant_j = ABITS'($urandom);
        w.model_00 = extreme ? 32'h8000_8000 : rnd_cplx();
        w.model_01 = extreme ? 32'h7FFF_7FFF : rnd_cplx();
        w.model_10 = extreme ? 32'h7FFF_8000 : rnd_cplx();
        w.model_11 = extreme ? 32'h8000_7FFF : rnd_cplx();
        w.obs_00 = $urandom; w.obs_01 = $urandom;
        w.obs_10 = $urandom; w.obs_11 = $urandom;
        w.last_baseline = 1'($urandom);
        ant_loaded[a] = 1'b1;
        return w;
    endfunction

    function automatic int pick_loaded();
        int a;
        do a = $urandom_range(NANT - 1); while (!ant_loaded[a]);
        return a;
    endfunction

    function automatic jmr_pkg::in_word_t compute_word();
        jmr_pkg::in_word_t w;
        w.req_type = jmr_pkg::REQ_COMPUTE;
        w.ant_i = ABITS'(pick_loaded());
        w.ant_j = ABITS'(pick_loaded());
        w.model_00 = rnd_cplx(); w.model_01 = rnd_cplx();
        w.model_10 = rnd_cplx(); w.model_11 = rnd_cplx();
        w.obs_00 = rnd_cplx(); w.obs_01 = rnd_cplx();
        w.obs_10 = rnd_cplx(); w.obs_11 = rnd_cplx();
        w.last_baseline = 1'($urandom);
        return w;
    endfunction

    task automatic drain();
        while (pending_q.size() > 0 || in_valid || residual_q.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        jmr_pkg::in_word_t w;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, unit matrices, self baseline, all-zero data
        pending_q.push_back(load_word(0, 1'b1));
        pending_q.push_back(load_word(NANT - 1, 1'b1));
        w = load_word(1, 1'b0);
        w.model_00 = 32'h1000_0000; w.model_01 = '0; w.model_10 = '0;
        w.model_11 = 32'h1000_0000;
        pending_q.push_back(w);
        for (int n = 0; n < 12; n++) begin
            w = compute_word();
            w.ant_i = (n & 1) ? ABITS'(0) : ABITS'(NANT - 1);
            w.ant_j = (n & 2) ? ABITS'(1) : ABITS'(0);
            if (n < 4) begin
                w.model_00 = 32'h8000_8000; w.model_01 = 32'h7FFF_7FFF;
                w.model_10 = 32'h8000_7FFF; w.model_11 = 32'h7FFF_8000;
                w.obs_00 = (n < 2) ? 32'h7FFF_7FFF : 32'h8000_8000;
            end else if (n < 6) begin
                w = '0; w.req_type = jmr_pkg::REQ_COMPUTE;
                w.ant_i = ABITS'(1); w.ant_j = ABITS'(1);
                w.last_baseline = n[0];
            end
            pending_q.push_back(w);
        end
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? 63 : (ph == 4 ? 8 : 0);
            recv_stall_pct = (ph == 2 || ph == 3) ? 63 : (ph == 4 ? 8 : 0);
            if (ph == 0)
                hold_cycles = 300;
            for (int n = 0; n < 320; n++)
                if ($urandom_range(99) < 15)
                    pending_q.push_back(load_word($urandom_range(NANT - 1), 1'b0));
                else
                    pending_q.push_back(compute_word());
            drain();
        end
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
